### design/apv_pkg.sv
// apv_pkg: shared types and constants for the archive path validator
// beat structs, error codes, byte constants and utf-8 limits
// no dependencies
package apv_pkg;

    // path length limit and counter width
    localparam int MAX_PATH_BYTES = 2048;
    localparam int COUNT_W        = $clog2(MAX_PATH_BYTES + 1);

    // verdict codes
    localparam logic [3:0] ERR_OK          = 4'd0;
    localparam logic [3:0] ERR_EMPTY       = 4'd1;
    localparam logic [3:0] ERR_TOO_LONG    = 4'd2;
    localparam logic [3:0] ERR_BAD_UTF8    = 4'd3;
    localparam logic [3:0] ERR_LEAD_SLASH  = 4'd4;
    localparam logic [3:0] ERR_NUL         = 4'd5;
    localparam logic [3:0] ERR_CONTROL     = 4'd6;
    localparam logic [3:0] ERR_BACKSLASH   = 4'd7;
    localparam logic [3:0] ERR_DOTDOT      = 4'd8;
    localparam logic [3:0] ERR_DIR_NOSLASH = 4'd9;
    localparam logic [3:0] ERR_FILE_SLASH  = 4'd10;

    // first bad character kinds
    localparam logic [1:0] FCE_NONE      = 2'd0;
    localparam logic [1:0] FCE_NUL       = 2'd1;
    localparam logic [1:0] FCE_CONTROL   = 2'd2;
    localparam logic [1:0] FCE_BACKSLASH = 2'd3;

    // utf-8 sequence classes (minimum code point of the sequence)
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_TWO   = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR  = 2'd3;

    // byte values
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] LEAD_MAX4    = 8'hF4;

    // code point limits
    localparam logic [20:0] CP_MIN_TWO   = 21'h00080;
    localparam logic [20:0] CP_MIN_THREE = 21'h00800;
    localparam logic [20:0] CP_MIN_FOUR  = 21'h10000;
    localparam logic [20:0] CP_SURR_LO   = 21'h0D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h0DFFF;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       is_directory;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic       path_ok;
        logic [3:0] error_code;
    } t_out_beat;

endpackage

### design/apv_in_stage.sv
// apv_in_stage: input register of the path validator
// holds one input beat until the check stage takes it
// depends on apv_pkg
module apv_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  apv_pkg::t_in_beat i_beat,
    input  logic              i_advance,
    output logic              o_valid,
    output apv_pkg::t_in_beat o_beat
);
    import apv_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    // take a new beat when empty or when the held one moves on
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### design/apv_check.sv
// apv_check: per-path check state, its one-byte update and the verdict logic
// state advances on every taken beat and returns to reset after the last one
// depends on apv_pkg
module apv_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  apv_pkg::t_in_beat  i_beat,
    output logic               o_res_valid,
    output apv_pkg::t_out_beat o_res
);
    import apv_pkg::*;

    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic               r_too_long, n_too_long;
    logic [1:0]         r_utf8_remaining, n_utf8_remaining;
    logic [1:0]         r_utf8_min_class, n_utf8_min_class;
    logic [20:0]        r_utf8_code, n_utf8_code;
    logic               r_utf8_bad, n_utf8_bad;
    logic               r_leading_slash, n_leading_slash;
    logic [1:0]         r_first_char_error, n_first_char_error;
    logic [1:0]         r_segment_length, n_segment_length;
    logic               r_segment_all_dots, n_segment_all_dots;
    logic               r_dotdot_seen, n_dotdot_seen;
    logic               r_prev_was_slash, n_prev_was_slash;

    logic [7:0]  c;
    logic        first;
    logic [20:0] code_shift;
    logic [20:0] min_val;
    logic [3:0]  verdict;

    // byte update
    always_comb begin
        n_byte_count       = r_byte_count;
        n_too_long         = r_too_long;
        n_utf8_remaining   = r_utf8_remaining;
        n_utf8_min_class   = r_utf8_min_class;
        n_utf8_code        = r_utf8_code;
        n_utf8_bad         = r_utf8_bad;
        n_leading_slash    = r_leading_slash;
        n_first_char_error = r_first_char_error;
        n_segment_length   = r_segment_length;
        n_segment_all_dots = r_segment_all_dots;
        n_dotdot_seen      = r_dotdot_seen;
        n_prev_was_slash   = r_prev_was_slash;

        c          = i_beat.byte_value;
        first      = (r_byte_count == '0) && !r_too_long;
        code_shift = {r_utf8_code[14:0], c[5:0]};

        case (r_utf8_min_class)
            CLS_TWO:   min_val = CP_MIN_TWO;
            CLS_THREE: min_val = CP_MIN_THREE;
            default:   min_val = CP_MIN_FOUR;
        endcase

        if (i_beat.has_byte) begin
            // saturating length count
            if (r_byte_count >= COUNT_W'(MAX_PATH_BYTES)) begin
                n_too_long = 1'b1;
            end else begin
                n_byte_count = r_byte_count + COUNT_W'(1);
            end

            // utf-8 decoder, sticky on error
            if (!r_utf8_bad) begin
                if (r_utf8_remaining != 2'd0) begin
                    if (c[7:6] != 2'b10) begin
                        n_utf8_bad = 1'b1;
                    end else begin
                        n_utf8_code      = code_shift;
                        n_utf8_remaining = r_utf8_remaining - 2'd1;
                        if (r_utf8_remaining == 2'd1) begin
                            if (code_shift < min_val ||
                                (code_shift >= CP_SURR_LO && code_shift <= CP_SURR_HI) ||
                                code_shift > CP_MAX) begin
                                n_utf8_bad = 1'b1;
                            end
                        end
                    end
                end else if (c[7]) begin
                    if (c[7:5] == 3'b110) begin
                        if (c[4:1] == 4'd0) begin
                            n_utf8_bad = 1'b1;
                        end else begin
                            n_utf8_remaining = 2'd1;
                            n_utf8_min_class = CLS_TWO;
                            n_utf8_code      = {16'd0, c[4:0]};
                        end
                    end else if (c[7:4] == 4'b1110) begin
                        n_utf8_remaining = 2'd2;
                        n_utf8_min_class = CLS_THREE;
                        n_utf8_code      = {17'd0, c[3:0]};
                    end else if (c[7:3] == 5'b11110) begin
                        if (c > LEAD_MAX4) begin
                            n_utf8_bad = 1'b1;
                        end else begin
                            n_utf8_remaining = 2'd3;
                            n_utf8_min_class = CLS_FOUR;
                            n_utf8_code      = {18'd0, c[2:0]};
                        end
                    end else begin
                        n_utf8_bad = 1'b1;
                    end
                end
            end

            // leading slash
            if (first && c == CH_SLASH) begin
                n_leading_slash = 1'b1;
            end

            // first forbidden character
            if (r_first_char_error == FCE_NONE) begin
                if (c == CH_NUL) begin
                    n_first_char_error = FCE_NUL;
                end else if (c < CH_SPACE) begin
                    n_first_char_error = FCE_CONTROL;
                end else if (c == CH_BACKSLASH) begin
                    n_first_char_error = FCE_BACKSLASH;
                end
            end

            // segment tracking for dot-dot and trailing slash
            if (c == CH_SLASH) begin
                if (r_segment_length == 2'd2 && r_segment_all_dots) begin
                    n_dotdot_seen = 1'b1;
                end
                n_segment_length   = 2'd0;
                n_segment_all_dots = 1'b1;
                n_prev_was_slash   = 1'b1;
            end else begin
                if (r_segment_length != 2'd3) begin
                    n_segment_length = r_segment_length + 2'd1;
                end
                if (c != CH_DOT) begin
                    n_segment_all_dots = 1'b0;
                end
                n_prev_was_slash = 1'b0;
            end
        end

        // verdict on the updated state
        if (n_byte_count == '0 && !n_too_long) begin
            verdict = ERR_EMPTY;
        end else if (n_too_long) begin
            verdict = ERR_TOO_LONG;
        end else if (n_utf8_bad || n_utf8_remaining != 2'd0) begin
            verdict = ERR_BAD_UTF8;
        end else if (n_leading_slash) begin
            verdict = ERR_LEAD_SLASH;
        end else if (n_first_char_error == FCE_NUL) begin
            verdict = ERR_NUL;
        end else if (n_first_char_error == FCE_CONTROL) begin
            verdict = ERR_CONTROL;
        end else if (n_first_char_error == FCE_BACKSLASH) begin
            verdict = ERR_BACKSLASH;
        end else if (n_dotdot_seen || (n_segment_length == 2'd2 && n_segment_all_dots)) begin
            verdict = ERR_DOTDOT;
        end else if (i_beat.is_directory && !n_prev_was_slash) begin
            verdict = ERR_DIR_NOSLASH;
        end else if (!i_beat.is_directory && n_prev_was_slash) begin
            verdict = ERR_FILE_SLASH;
        end else begin
            verdict = ERR_OK;
        end
    end

    assign o_res_valid      = i_take && i_beat.last;
    assign o_res.path_ok    = (verdict == ERR_OK);
    assign o_res.error_code = verdict;

    // state registers, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_beat.last)) begin
            r_byte_count       <= '0;
            r_too_long         <= 1'b0;
            r_utf8_remaining   <= 2'd0;
            r_utf8_min_class   <= CLS_NONE;
            r_utf8_code        <= '0;
            r_utf8_bad         <= 1'b0;
            r_leading_slash    <= 1'b0;
            r_first_char_error <= FCE_NONE;
            r_segment_length   <= 2'd0;
            r_segment_all_dots <= 1'b1;
            r_dotdot_seen      <= 1'b0;
            r_prev_was_slash   <= 1'b0;
        end else if (i_take) begin
            r_byte_count       <= n_byte_count;
            r_too_long         <= n_too_long;
            r_utf8_remaining   <= n_utf8_remaining;
            r_utf8_min_class   <= n_utf8_min_class;
            r_utf8_code        <= n_utf8_code;
            r_utf8_bad         <= n_utf8_bad;
            r_leading_slash    <= n_leading_slash;
            r_first_char_error <= n_first_char_error;
            r_segment_length   <= n_segment_length;
            r_segment_all_dots <= n_segment_all_dots;
            r_dotdot_seen      <= n_dotdot_seen;
            r_prev_was_slash   <= n_prev_was_slash;
        end
    end

`ifndef SYNTHESIS
    // length counter stays within the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= COUNT_W'(MAX_PATH_BYTES))
        else $error("byte count above limit");

    // overflow flag only once the counter has saturated
    a_too_long_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> (r_byte_count == COUNT_W'(MAX_PATH_BYTES)))
        else $error("too_long set before saturation");

    // a slash always opens a fresh segment
    a_slash_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_was_slash |-> (r_segment_length == 2'd0 && r_segment_all_dots))
        else $error("segment state inconsistent after slash");

    // state is back at reset after a verdict
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_beat.last) |=>
            (r_byte_count == '0 && !r_too_long && r_utf8_remaining == 2'd0 &&
             !r_utf8_bad && r_first_char_error == FCE_NONE))
        else $error("state not cleared after verdict");
`endif

endmodule

### design/apv_out_stage.sv
// apv_out_stage: result register of the path validator
// holds one verdict beat until the consumer takes it
// depends on apv_pkg
module apv_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  apv_pkg::t_out_beat i_res,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output apv_pkg::t_out_beat o_res
);
    import apv_pkg::*;

    logic      r_valid;
    t_out_beat r_res;

    // room when empty or when the held beat leaves this cycle
    assign o_can_load = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### design/archive_path_validator_unit.sv
// archive_path_validator_unit: top level of the archive entry path validator
// input register, check stage with per-path state, result register
// depends on apv_pkg, apv_in_stage, apv_check, apv_out_stage
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------
//   in      | in  | i_in_valid/o_in_ready  | i_in  (byte, flags, last)
//   out     | out | o_out_valid/i_out_ready| o_out (path_ok, error_code)
//
// one path byte per cycle unless a stalled result holds the check stage; o_out_valid rises
// when the check logic, fed by the input register, loads the verdict of a path's last beat
// the whole per-byte update is one pass of flag and shift logic in apv_check
// reset is synchronous and active low; it empties both registers and clears
// the path state
// a stalled result holds the check stage; the input register still takes
// one more beat, after which o_in_ready follows i_out_ready
module archive_path_validator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  apv_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output apv_pkg::t_out_beat o_out
);
    import apv_pkg::*;

    logic      stg_valid;
    t_in_beat  stg_beat;
    logic      can_load;
    logic      take;
    logic      res_valid;
    t_out_beat res;

    // check stage moves when the result register has room
    assign take = stg_valid && can_load;

    apv_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_beat    (i_in),
        .i_advance (can_load),
        .o_valid   (stg_valid),
        .o_beat    (stg_beat)
    );

    apv_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_beat      (stg_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    apv_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (o_out)
    );

endmodule

### verif/tb.sv
// tb: self-checking bench for archive_path_validator_unit
// sends directed and random entry paths byte by byte and checks every verdict
// against an in-bench path model; depends on apv_pkg and the validator top level
module tb;
    import apv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int SHORT_ITEMS    = 1400;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out;

    archive_path_validator_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // path model state
    logic [COUNT_W-1:0] m_count;
    logic               m_too_long;
    logic [1:0]         m_left;
    logic [1:0]         m_cls;
    logic [20:0]        m_cp;
    logic               m_bad;
    logic               m_lead_slash;
    logic [1:0]         m_fce;
    logic [1:0]         m_seg_len;
    logic               m_seg_dots;
    logic               m_dotdot;
    logic               m_prev_slash;

    t_out_beat  verdict_q[$];
    t_in_beat   stim_q[$];
    logic [7:0] pb[$];

    int  n_total    = 0;
    int  n_real     = 0;
    int  n_sent     = 0;
    int  n_accepted = 0;
    int  phase_len  = 0;
    int  fails      = 0;
    int  quiet      = 0;
    int  send_idle  = 0;
    int  recv_stall = 0;
    bit  in_taken   = 1'b0;

    task automatic clear_path_state();
        m_count      = '0;
        m_too_long   = 1'b0;
        m_left       = 2'd0;
        m_cls        = CLS_NONE;
        m_cp         = '0;
        m_bad        = 1'b0;
        m_lead_slash = 1'b0;
        m_fce        = FCE_NONE;
        m_seg_len    = 2'd0;
        m_seg_dots   = 1'b1;
        m_dotdot     = 1'b0;
        m_prev_slash = 1'b0;
    endtask

    // utf-8 decoder, sticky once a sequence fails
    task automatic decode_utf8(input logic [7:0] c);
        logic [20:0] lo;
        if (m_bad)
            return;
        if (m_left != 2'd0) begin
            if (c[7:6] != 2'b10) begin
                m_bad = 1'b1;
                return;
            end
            m_cp   = {m_cp[14:0], c[5:0]};
            m_left = m_left - 2'd1;
            if (m_left == 2'd0) begin
                case (m_cls)
                    CLS_TWO:   lo = CP_MIN_TWO;
                    CLS_THREE: lo = CP_MIN_THREE;
                    default:   lo = CP_MIN_FOUR;
                endcase
                if (m_cp < lo || (m_cp >= CP_SURR_LO && m_cp <= CP_SURR_HI) || m_cp > CP_MAX)
                    m_bad = 1'b1;
            end
        end else if (c[7] == 1'b0) begin
            m_cls = m_cls;
        end else if (c[7:5] == 3'b110) begin
            if (c[4:1] == 4'd0) begin
                m_bad = 1'b1;
            end else begin
                m_left = 2'd1;
                m_cls  = CLS_TWO;
                m_cp   = {16'd0, c[4:0]};
            end
        end else if (c[7:4] == 4'b1110) begin
            m_left = 2'd2;
            m_cls  = CLS_THREE;
            m_cp   = {17'd0, c[3:0]};
        end else if (c[7:3] == 5'b11110) begin
            if (c > LEAD_MAX4) begin
                m_bad = 1'b1;
            end else begin
                m_left = 2'd3;
                m_cls  = CLS_FOUR;
                m_cp   = {18'd0, c[2:0]};
            end
        end else begin
            m_bad = 1'b1;
        end
    endtask

    task automatic take_path_byte(input logic [7:0] c);
        logic first;
        first = (m_count == '0) && !m_too_long;
        if (m_count >= MAX_PATH_BYTES)
            m_too_long = 1'b1;
        else
            m_count = m_count + 1'b1;
        decode_utf8(c);
        if (first && c == CH_SLASH)
            m_lead_slash = 1'b1;
        if (m_fce == FCE_NONE) begin
            if (c == CH_NUL)
                m_fce = FCE_NUL;
            else if (c < CH_SPACE)
                m_fce = FCE_CONTROL;
            else if (c == CH_BACKSLASH)
                m_fce = FCE_BACKSLASH;
        end
        // segment tracking for dotdot and trailing slash
        if (c == CH_SLASH) begin
            if (m_seg_len == 2'd2 && m_seg_dots)
                m_dotdot = 1'b1;
            m_seg_len    = 2'd0;
            m_seg_dots   = 1'b1;
            m_prev_slash = 1'b1;
        end else begin
            if (m_seg_len < 2'd3)
                m_seg_len = m_seg_len + 2'd1;
            if (c != CH_DOT)
                m_seg_dots = 1'b0;
            m_prev_slash = 1'b0;
        end
    endtask

    function automatic t_out_beat path_verdict(input logic dir);
        t_out_beat  v;
        logic [3:0] code;
        if (m_count == '0 && !m_too_long)
            code = ERR_EMPTY;
        else if (m_too_long)
            code = ERR_TOO_LONG;
        else if (m_bad || m_left != 2'd0)
            code = ERR_BAD_UTF8;
        else if (m_lead_slash)
            code = ERR_LEAD_SLASH;
        else if (m_fce == FCE_NUL)
            code = ERR_NUL;
        else if (m_fce == FCE_CONTROL)
            code = ERR_CONTROL;
        else if (m_fce == FCE_BACKSLASH)
            code = ERR_BACKSLASH;
        else if (m_dotdot || (m_seg_len == 2'd2 && m_seg_dots))
            code = ERR_DOTDOT;
        else if (dir && !m_prev_slash)
            code = ERR_DIR_NOSLASH;
        else if (!dir && m_prev_slash)
            code = ERR_FILE_SLASH;
        else
            code = ERR_OK;
        v.path_ok    = (code == ERR_OK);
        v.error_code = code;
        return v;
    endfunction

    task automatic path_model_take(input t_in_beat b);
        if (b.has_byte)
            take_path_byte(b.byte_value);
        if (b.last) begin
            verdict_q.insert(verdict_q.size(), path_verdict(b.is_directory));
            clear_path_state();
        end
    endtask

    // stimulus building
    task automatic push_beat(input logic [7:0] b, input logic has, input logic dir,
                             input logic last);
        t_in_beat t;
        t.byte_value   = b;
        t.has_byte     = has;
        t.is_directory = dir;
        t.last         = last;
        stim_q.insert(stim_q.size(), t);
        n_total++;
        if (has || last)
            n_real++;
    endtask

    // append one byte to the path being built
    task automatic add_byte(input logic [7:0] b);
        pb.insert(pb.size(), b);
    endtask

    // send the bytes in pb as one path, optionally closing it with a byteless last beat
    task automatic emit_path(input logic dir, input logic split_end, input int noise_pct);
        int  i;
        int  n;
        logic lst;
        n = pb.size();
        if (n == 0) begin
            push_beat(8'($urandom), 1'b0, dir, 1'b1);
            return;
        end
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
            lst = (i == n - 1) && !split_end;
            push_beat(pb[i], 1'b1, lst ? dir : logic'($urandom_range(0, 1)), lst);
        end
        if (split_end)
            push_beat(8'($urandom), 1'b0, dir, 1'b1);
        pb.delete();
    endtask

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // raw utf-8 encoding, no validity check, so overlong and out of range forms work too
    task automatic add_utf8(input logic [20:0] cp, input int n);
        case (n)
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_good_utf8();
        int          r;
        logic [20:0] cp;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            add_utf8(21'($urandom_range('h80, 'h7FF)), 2);
        end else if (r < 60) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                cp = cp + 21'h800;
            add_utf8(cp, 3);
        end else if (r < 85) begin
            add_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
        end else begin
            // boundary code points
            case ($urandom_range(0, 7))
                0: add_utf8(CP_MIN_TWO, 2);
                1: add_utf8(21'h7FF, 2);
                2: add_utf8(CP_MIN_THREE, 3);
                3: add_utf8(CP_SURR_LO - 21'd1, 3);
                4: add_utf8(CP_SURR_HI + 21'd1, 3);
                5: add_utf8(21'hFFFF, 3);
                6: add_utf8(CP_MIN_FOUR, 4);
                default: add_utf8(CP_MAX, 4);
            endcase
        end
    endtask

    task automatic add_bad_utf8();
        int i;
        case ($urandom_range(0, 9))
            0: add_utf8(21'($urandom_range(0, 'h7F)), 2);
            1: add_utf8(21'($urandom_range(0, 'h7FF)), 3);
            2: add_utf8(21'($urandom_range(0, 'hFFFF)), 4);
            3: add_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
            4: add_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            5: add_byte(8'h80 | 8'($urandom_range(0, 63)));
            6: add_byte(8'($urandom_range('hF8, 'hFF)));
            7: begin
                // lead byte cut short by a plain character
                add_byte(8'hE0 | 8'($urandom_range(0, 15)));
                add_byte(8'h61);
            end
            8: begin
                // truncated sequence, possibly at the end of the path
                add_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
                for (i = $urandom_range(1, 3); i > 0; i--)
                    void'(pb.pop_back());
            end
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic add_segment(input int bad_pct);
        int         k;
        int         j;
        int         r;
        logic [7:0] c;
        k = $urandom_range(0, 99);
        if (k < 8) begin
            add_str(".");
        end else if (k < 16) begin
            add_str("..");
        end else if (k < 20) begin
            add_str("...");
        end else begin
            for (j = $urandom_range(1, 6); j > 0; j--) begin
                r = $urandom_range(0, 99);
                if (r < bad_pct) begin
                    case ($urandom_range(0, 4))
                        0: add_byte(CH_NUL);
                        1: add_byte(8'($urandom_range(1, 'h1F)));
                        2: add_byte(CH_BACKSLASH);
                        3: add_bad_utf8();
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end else if (r < 75) begin
                    c = 8'($urandom_range(CH_SPACE, 'h7F));
                    if (c == CH_SLASH || c == CH_BACKSLASH)
                        c = 8'h78;
                    add_byte(c);
                end else begin
                    add_good_utf8();
                end
            end
        end
    endtask

    task automatic add_random_path();
        logic dir;
        int   nseg;
        int   s;
        int   bad_pct;
        dir     = 1'($urandom_range(0, 1));
        bad_pct = ($urandom_range(0, 99) < 25) ? 15 : 0;
        if ($urandom_range(0, 99) < 6)
            add_byte(CH_SLASH);
        nseg = $urandom_range(1, 4);
        for (s = 0; s < nseg; s++) begin
            add_segment(bad_pct);
            if (s < nseg - 1) begin
                add_byte(CH_SLASH);
                if ($urandom_range(0, 99) < 5)
                    add_byte(CH_SLASH);
            end
        end
        if ($urandom_range(0, 99) < (dir ? 85 : 10))
            add_byte(CH_SLASH);
        if ($urandom_range(0, 99) < 3)
            pb.delete();
        emit_path(dir, $urandom_range(0, 3) == 0, 4);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (n_sent < phase_len) begin
                send_idle  = 23;
                recv_stall = 77;
            end else if (n_sent < 2 * phase_len) begin
                send_idle  = 77;
                recv_stall = 23;
            end else begin
                send_idle  = 0;
                recv_stall = 0;
            end
            busy = i_in_valid && !in_taken;
            if (!busy) begin
                if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_in       <= stim_q.pop_front();
                    i_in_valid <= 1'b1;
                    n_sent++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= 10)
            $display("%s", msg);
    endtask

    // monitor: beats sampled on the rising edge, plus the watchdog
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            quiet++;
            if (i_in_valid && o_in_ready) begin
                path_model_take(i_in);
                in_taken = 1'b1;
                n_accepted++;
                quiet = 0;
            end
            if (o_out_valid && i_out_ready) begin
                quiet = 0;
                if (verdict_q.size() == 0) begin
                    note_fail($sformatf("unexpected verdict ok=%0d code=%0d",
                                        o_out.path_ok, o_out.error_code));
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out.path_ok !== want.path_ok || o_out.error_code !== want.error_code)
                        note_fail($sformatf("verdict mismatch: expected ok=%0d code=%0d, got ok=%0d code=%0d",
                                            want.path_ok, want.error_code,
                                            o_out.path_ok, o_out.error_code));
                end
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_in        = '0;
        clear_path_state();

        // directed paths
        emit_path(1'b0, 1'b0, 0);
        push_beat(8'hFF, 1'b0, 1'b1, 1'b0);
        add_str("a");
        emit_path(1'b0, 1'b0, 0);
        add_str("d/");
        emit_path(1'b1, 1'b1, 0);
        add_str("d");
        emit_path(1'b1, 1'b0, 0);
        add_str("f/");
        emit_path(1'b0, 1'b0, 0);
        add_str("/a");
        emit_path(1'b0, 1'b0, 0);
        add_byte(8'h1F);
        add_byte(CH_BACKSLASH);
        emit_path(1'b0, 1'b0, 0);
        add_byte(CH_BACKSLASH);
        add_byte(CH_NUL);
        emit_path(1'b0, 1'b0, 0);
        add_byte(CH_NUL);
        add_byte(8'h01);
        emit_path(1'b0, 1'b0, 0);
        add_str("..");
        emit_path(1'b0, 1'b0, 0);
        add_byte(8'hC0);
        add_byte(8'h80);
        emit_path(1'b0, 1'b0, 0);
        add_byte(8'hE2);
        add_byte(8'h82);
        emit_path(1'b0, 1'b0, 0);
        add_utf8(21'h110000, 4);
        emit_path(1'b0, 1'b0, 0);

        // random paths
        while (n_real < SHORT_ITEMS)
            add_random_path();
        phase_len = n_total / 3;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_total || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
